/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/core/c2d_pkg.sv */
// Package: types and constants for the 2D convolution block.
`timescale 1ns / 1ps
package c2d_pkg;
	localparam int MaxInCh = 16;
	localparam int MaxOutCh = 16;
	localparam int MaxKernel = 5;
	localparam int MaxHeight = 64;
	localparam int MaxWidth = 64;

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_BIAS   = 2'd1,
		CMD_PIXEL  = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OUT  = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	localparam logic [2:0] REG_IN_CH  = 3'd0;
	localparam logic [2:0] REG_OUT_CH = 3'd1;
	localparam logic [2:0] REG_KSIZE  = 3'd2;
	localparam logic [2:0] REG_STRIDE = 3'd3;
	localparam logic [2:0] REG_PAD    = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;
	localparam logic [2:0] REG_WIDTH  = 3'd6;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         out_channel;
		logic [3:0]         in_channel;
		logic [2:0]         tap_row;
		logic [2:0]         tap_col;
		logic [6:0]         row;
		logic [6:0]         col;
		logic signed [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sum;
		logic [1:0]         status;
	} out_item_t;

	// Control from sequencer to accumulator.
	typedef struct packed {
		logic clr;   // load bias, start new sum
		logic mac;   // accumulate product
		logic done;  // result state; c2d_acc registers it but does not use it
	} acc_ctl_t;
endpackage

/* rtl/core/conv2d_forward_padded_strided.sv */
// Top level: 2D convolution, loads into memories, queries walked by one MAC.
// Loads write the memories as they are accepted. A query walks its Cin*K*K taps,
// one tap per cycle from the pixel and weight memories into the shared MAC.
// A query outside the output map is answered with ST_OUT from the check state.
// Reset (arst_n low, asynchronous) restores registers to 1,1,3,1,0,64,64 and
// clears the bias valid bits; pixel and weight memories are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module conv2d_forward_padded_strided #(
	parameter int MAX_IN_CH  = c2d_pkg::MaxInCh,
	parameter int MAX_OUT_CH = c2d_pkg::MaxOutCh,
	parameter int MAX_KERNEL = c2d_pkg::MaxKernel,
	parameter int MAX_HEIGHT = c2d_pkg::MaxHeight,
	parameter int MAX_WIDTH  = c2d_pkg::MaxWidth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  c2d_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output c2d_pkg::out_item_t   out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [6:0]           cfg_data
);
	localparam int IcW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
	localparam int OcW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
	localparam int HW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int KK  = MAX_KERNEL * MAX_KERNEL;
	localparam int PixDepth = MAX_IN_CH * MAX_HEIGHT * MAX_WIDTH;
	localparam int WgtDepth = MAX_OUT_CH * MAX_IN_CH * KK;
	localparam int PaW = $clog2(PixDepth + 1);
	localparam int WaW = $clog2(WgtDepth + 1);
	localparam int ICAP = (MAX_IN_CH < 16) ? MAX_IN_CH : 16;
	localparam int OCAP = (MAX_OUT_CH < 16) ? MAX_OUT_CH : 16;
	localparam int KCAP = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;
	localparam int HCAP = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
	localparam int WCAP = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_RUN, S_DRAIN, S_SAT, S_OUT} state_t;

	state_t state_q;
	logic [4:0] icu_q, ocu_q;
	logic [2:0] ks_q, st_q, pad_q;
	logic [6:0] h_q, w_q;

	logic signed [15:0] pix_mem [PixDepth];
	logic signed [15:0] wgt_mem [WgtDepth];
	logic signed [15:0] bias_q [MAX_OUT_CH];
	logic [MAX_OUT_CH-1:0] bias_vld_q;

	c2d_pkg::in_item_t q_q;
	logic [4:0] ic_q;
	logic [2:0] kr_q, kc_q;
	logic [3:0] drain_q;
	logic signed [15:0] pix_rd_s1, wgt_rd_s1;
	logic pzero_s1;
	c2d_pkg::acc_ctl_t ctl;
	logic signed [31:0] acc_sum;
	logic acc_sat;
	c2d_pkg::out_item_t out_q;
	logic out_vld_q;

	function automatic logic [6:0] clampv(logic [6:0] v, int lo, int hi);
		logic [6:0] r;
		r = v;
		if (int'(v) < lo) r = 7'(lo);
		if (int'(v) > hi) r = 7'(hi);
		return r;
	endfunction

	assign cfg_ready = (state_q == S_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icu_q <= 5'd1; ocu_q <= 5'd1; ks_q <= 3'(KCAP < 3 ? KCAP : 3);
			st_q <= 3'd1; pad_q <= 3'd0; h_q <= 7'(HCAP); w_q <= 7'(WCAP);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				c2d_pkg::REG_IN_CH:  icu_q <= 5'(clampv({2'b0, cfg_data[4:0]}, 1, ICAP));
				c2d_pkg::REG_OUT_CH: ocu_q <= 5'(clampv({2'b0, cfg_data[4:0]}, 1, OCAP));
				c2d_pkg::REG_KSIZE:  ks_q <= 3'(clampv({4'b0, cfg_data[2:0]}, 1, KCAP));
				c2d_pkg::REG_STRIDE: st_q <= 3'(clampv({4'b0, cfg_data[2:0]}, 1, 4));
				c2d_pkg::REG_PAD:    pad_q <= 3'(clampv({4'b0, cfg_data[2:0]}, 0, 4));
				c2d_pkg::REG_HEIGHT: h_q <= clampv(cfg_data, 1, HCAP);
				c2d_pkg::REG_WIDTH:  w_q <= clampv(cfg_data, 1, WCAP);
				default: ;
			endcase
		end
	end

	// Load decode
	logic acc_in;
	assign in_ready = (state_q == S_IDLE) && !out_vld_q;
	assign acc_in = in_valid && in_ready;
	logic wld_ok, pld_ok, bld_ok;
	assign wld_ok = int'(in_data.out_channel) < MAX_OUT_CH && int'(in_data.in_channel) < MAX_IN_CH
		&& int'(in_data.tap_row) < MAX_KERNEL && int'(in_data.tap_col) < MAX_KERNEL;
	assign pld_ok = int'(in_data.in_channel) < MAX_IN_CH && int'(in_data.row) < MAX_HEIGHT
		&& int'(in_data.col) < MAX_WIDTH;
	assign bld_ok = int'(in_data.out_channel) < MAX_OUT_CH;

	logic [PaW-1:0] pwa;
	logic [WaW-1:0] wwa;
	assign pwa = PaW'((int'(in_data.in_channel) * MAX_HEIGHT + int'(in_data.row)) * MAX_WIDTH
		+ int'(in_data.col));
	assign wwa = WaW'(((int'(in_data.out_channel) * MAX_IN_CH + int'(in_data.in_channel))
		* MAX_KERNEL + int'(in_data.tap_row)) * MAX_KERNEL + int'(in_data.tap_col));

	// Query address generation
	logic signed [9:0] py, px;
	logic pin;
	logic [PaW-1:0] pra;
	logic [WaW-1:0] wra;
	assign py = 10'(signed'({3'b0, q_q.row}) * signed'({7'b0, st_q})) + 10'(kr_q)
		- 10'(pad_q);
	assign px = 10'(signed'({3'b0, q_q.col}) * signed'({7'b0, st_q})) + 10'(kc_q)
		- 10'(pad_q);
	assign pin = (py >= 0) && (px >= 0) && (py < signed'({3'b0, h_q}))
		&& (px < signed'({3'b0, w_q}));
	assign pra = PaW'((int'(ic_q) * MAX_HEIGHT + int'(py[HW-1:0])) * MAX_WIDTH
		+ int'(px[WW-1:0]));
	assign wra = WaW'(((int'(q_q.out_channel) * MAX_IN_CH + int'(ic_q)) * MAX_KERNEL
		+ int'(kr_q)) * MAX_KERNEL + int'(kc_q));

	always_ff @(posedge clk) begin
		if (acc_in && in_data.cmd == c2d_pkg::CMD_PIXEL && pld_ok)
			pix_mem[pwa[$clog2(PixDepth)-1:0]] <= in_data.value;
		if (acc_in && in_data.cmd == c2d_pkg::CMD_WEIGHT && wld_ok)
			wgt_mem[wwa[$clog2(WgtDepth)-1:0]] <= in_data.value;
		pix_rd_s1 <= pix_mem[pra[$clog2(PixDepth)-1:0]];
		wgt_rd_s1 <= wgt_mem[wra[$clog2(WgtDepth)-1:0]];
		if (acc_in && in_data.cmd == c2d_pkg::CMD_BIAS && bld_ok)
			bias_q[in_data.out_channel[OcW-1:0]] <= in_data.value;
	end

	// Output map bounds
	logic signed [9:0] full_h, full_w, y0, x0;
	assign full_h = 10'(h_q) + 10'({pad_q, 1'b0}) - 10'(ks_q) + 10'sd1;
	assign full_w = 10'(w_q) + 10'({pad_q, 1'b0}) - 10'(ks_q) + 10'sd1;
	assign y0 = 10'(q_q.row) * 10'(st_q);
	assign x0 = 10'(q_q.col) * 10'(st_q);
	logic outside;
	assign outside = ({1'b0, q_q.out_channel} >= ocu_q) || full_h <= 0 || full_w <= 0
		|| y0 >= full_h || x0 >= full_w;

	logic signed [15:0] bias_sel;
	assign bias_sel = (int'(q_q.out_channel) < MAX_OUT_CH
		&& bias_vld_q[q_q.out_channel[OcW-1:0]]) ? bias_q[q_q.out_channel[OcW-1:0]] : 16'sd0;

	logic last_tap;
	assign last_tap = (kc_q == ks_q - 3'd1) && (kr_q == ks_q - 3'd1) && (ic_q == icu_q - 5'd1);

	logic mac_req;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bias_vld_q <= '0;
			out_vld_q <= 1'b0;
			mac_req <= 1'b0;
			pzero_s1 <= 1'b0;
			ic_q <= '0; kr_q <= '0; kc_q <= '0; drain_q <= '0;
		end else begin
			mac_req <= (state_q == S_RUN);
			pzero_s1 <= !pin;
			if (out_vld_q && out_ready) out_vld_q <= 1'b0;
			if (acc_in && in_data.cmd == c2d_pkg::CMD_BIAS && bld_ok)
				bias_vld_q[in_data.out_channel[OcW-1:0]] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (acc_in && in_data.cmd == c2d_pkg::CMD_QUERY) state_q <= S_CHECK;
					ic_q <= '0; kr_q <= '0; kc_q <= '0;
				end
				S_CHECK: begin
					if (outside) begin
						out_q <= '{sum: 32'sd0, status: c2d_pkg::ST_OUT};
						out_vld_q <= 1'b1;
						state_q <= S_IDLE;
					end else state_q <= S_RUN;
				end
				S_RUN: begin
					if (last_tap) begin
						state_q <= S_DRAIN;
						drain_q <= 4'd3;
					end else if (kc_q == ks_q - 3'd1) begin
						kc_q <= '0;
						if (kr_q == ks_q - 3'd1) begin
							kr_q <= '0;
							ic_q <= ic_q + 5'd1;
						end else kr_q <= kr_q + 3'd1;
					end else kc_q <= kc_q + 3'd1;
				end
				S_DRAIN: begin
					drain_q <= drain_q - 4'd1;
					if (drain_q == 4'd1) state_q <= S_SAT;
				end
				S_SAT: begin
					out_q <= '{sum: acc_sum,
						status: acc_sat ? c2d_pkg::ST_SAT : c2d_pkg::ST_OK};
					out_vld_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) q_q <= in_data;
	end

	// Memory data arrives in the cycle after its address; mac_req is registered to match.
	assign ctl.clr = (state_q == S_CHECK);
	assign ctl.mac = mac_req;
	assign ctl.done = (state_q == S_SAT);

	c2d_acc u_acc (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .bias(bias_sel),
		.pix(pzero_s1 ? 16'sd0 : pix_rd_s1), .wgt(wgt_rd_s1),
		.sum(acc_sum), .sat(acc_sat)
	);

	assign out_valid = out_vld_q;
	assign out_data = out_q;

	`ASSERT_NEVER(a_no_in_busy, clk, arst_n, acc_in && state_q != S_IDLE, "input while busy")
	`ASSERT_NEVER(a_no_cfg_busy, clk, arst_n, cfg_valid && cfg_ready && state_q != S_IDLE,
		"cfg while busy")
	`ASSERT_IMPL(a_sat_out, clk, arst_n, state_q == S_SAT |=> out_valid, "no result after sum")
	`ASSERT_IMPL(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")
endmodule

/* rtl/core/c2d_acc.sv */
// Multiply-accumulate unit with saturation to signed Q16.16.
`timescale 1ns / 1ps
module c2d_acc (
	input  logic               clk,
	input  logic               arst_n,
	input  c2d_pkg::acc_ctl_t  ctl,
	input  logic signed [15:0] bias,
	input  logic signed [15:0] pix,
	input  logic signed [15:0] wgt,
	output logic signed [31:0] sum,
	output logic               sat
);
	logic signed [31:0] prod_s1;
	logic               mac_s1;
	logic               done_s1;
	logic               done_s2;
	logic signed [47:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			done_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			mac_s1 <= ctl.mac;
			done_s1 <= ctl.done;
			done_s2 <= done_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= pix * wgt;
		if (ctl.clr)
			acc_q <= 48'(signed'({bias, 8'h00}));
		else if (mac_s1)
			acc_q <= acc_q + 48'(prod_s1);
	end

	always_comb begin
		sat = 1'b0;
		sum = acc_q[31:0];
		if (acc_q > 48'sh0000_7FFF_FFFF) begin
			sum = 32'sh7FFF_FFFF;
			sat = 1'b1;
		end else if (acc_q < -48'sh0000_8000_0000) begin
			sum = -32'sh8000_0000;
			sat = 1'b1;
		end
	end

	logic unused_done;
	assign unused_done = done_s2;
endmodule
